/* hdl/ftc_pkg.sv */
// ----------------------------------------------------------------------------
// ftc_pkg
// shared types, register indexes and double-precision helper functions
// ----------------------------------------------------------------------------
package ftc_pkg;

  localparam logic [1:0]  CFG_REL_TOL = 2'd0;
  localparam logic [1:0]  CFG_ABS_TOL = 2'd1;
  localparam logic [1:0]  CFG_NAN_EQ  = 2'd2;

  localparam logic [10:0] EXP_ALL     = 11'h7FF;
  localparam logic [63:0] QNAN_BITS   = 64'h7FF8_0000_0000_0000;

  // operand split into fields, subnormals get exponent 1 and no hidden bit
  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [10:0] exp;
    logic [52:0] mant;
  } unpacked_t;

  // adder front end: operands ordered by magnitude
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sign;
    logic        sub;
    logic [10:0] exp_big;
    logic [52:0] m_big;
    logic [52:0] m_small;
    logic [5:0]  shamt;
  } add_prep_t;

  // value = m * 2^(e - 1023 - 106), specials carried as flags
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sign;
    logic signed [13:0] e;
    logic [107:0]       m;
  } norm_in_t;

  function automatic unpacked_t unpack(input logic [63:0] v);
    unpacked_t   u;
    logic [10:0] f;
    f      = v[62:52];
    u.sign = v[63];
    u.nan  = (f == EXP_ALL) && (v[51:0] != 52'd0);
    u.inf  = (f == EXP_ALL) && (v[51:0] == 52'd0);
    u.zero = (f == 11'd0) && (v[51:0] == 52'd0);
    u.exp  = (f == 11'd0) ? 11'd1 : f;
    u.mant = {f != 11'd0, v[51:0]};
    return u;
  endfunction

  function automatic add_prep_t add_prep(input unpacked_t x, input unpacked_t y);
    add_prep_t   p;
    logic        x_big;
    logic        eq;
    logic [10:0] d;
    x_big       = {x.exp, x.mant} >= {y.exp, y.mant};
    eq          = {x.exp, x.mant} == {y.exp, y.mant};
    p.sub       = x.sign ^ y.sign;
    p.nan       = x.nan | y.nan | (x.inf & y.inf & p.sub);
    p.inf       = x.inf | y.inf;
    if (p.inf) begin
      p.sign = x.inf ? x.sign : y.sign;
    end else if (p.sub && eq) begin
      p.sign = 1'b0;
    end else begin
      p.sign = x_big ? x.sign : y.sign;
    end
    p.exp_big   = x_big ? x.exp : y.exp;
    p.m_big     = x_big ? x.mant : y.mant;
    p.m_small   = x_big ? y.mant : x.mant;
    d           = x_big ? (x.exp - y.exp) : (y.exp - x.exp);
    p.shamt     = (d > 11'd63) ? 6'd63 : d[5:0];
    return p;
  endfunction

  // align, add or subtract with guard, round and sticky bits
  function automatic norm_in_t add_core(input add_prep_t p);
    norm_in_t    n;
    logic [55:0] mb;
    logic [55:0] ms;
    logic [55:0] msh;
    logic [55:0] lost;
    logic [55:0] ys;
    logic [56:0] sum;
    mb   = {p.m_big, 3'b000};
    ms   = {p.m_small, 3'b000};
    msh  = ms >> p.shamt;
    lost = ms & ~({56{1'b1}} << p.shamt);
    ys   = {msh[55:1], msh[0] | (|lost)};
    sum  = p.sub ? ({1'b0, mb} - {1'b0, ys}) : ({1'b0, mb} + {1'b0, ys});
    n.nan  = p.nan;
    n.inf  = p.inf;
    n.sign = p.sign;
    n.e    = $signed({3'b000, p.exp_big});
    n.m    = {sum, 51'd0};
    return n;
  endfunction

  function automatic logic [6:0] lzc108(input logic [107:0] m);
    logic [6:0] n;
    n = 7'd108;
    for (int i = 0; i < 108; i++) begin
      if (m[i]) begin
        n = 7'(107 - i);
      end
    end
    return n;
  endfunction

endpackage

/* hdl/ftc_norm_round.sv */
// ----------------------------------------------------------------------------
// ftc_norm_round
// four-stage normalize and round-to-nearest-even unit, packs a double
// ----------------------------------------------------------------------------
module ftc_norm_round import ftc_pkg::*; (
  input  logic        clk,
  input  logic [3:0]  en,
  input  norm_in_t    op,
  output logic [63:0] result
);

  typedef struct packed {
    logic         nan;
    logic         inf;
    logic         sign;
    logic [107:0] m;
    logic         left;
    logic [6:0]   amt;
    logic [12:0]  fexp;
  } shift_st_t;

  typedef struct packed {
    logic         nan;
    logic         inf;
    logic         sign;
    logic [107:0] m;
    logic         sticky;
    logic [12:0]  fexp;
  } round_st_t;

  norm_in_t  s1;
  shift_st_t s2, s2_next;
  round_st_t s3, s3_next;
  logic [63:0] res_next;

  // leading-zero count and shift decision
  always_comb begin
    logic [6:0]         lz;
    logic signed [14:0] nexp;
    logic signed [14:0] shv;
    logic signed [14:0] ashv;
    lz           = lzc108(s1.m);
    nexp         = 15'(s1.e) + 15'sd1 - $signed({8'd0, lz});
    s2_next.nan  = s1.nan;
    s2_next.inf  = s1.inf;
    s2_next.sign = s1.sign;
    s2_next.m    = s1.m;
    if (nexp > 15'sd0) begin
      shv          = $signed({8'd0, lz}) - 15'sd1;
      s2_next.fexp = nexp[12:0];
    end else begin
      // subnormal: exponent pinned at its minimum
      shv          = 15'(s1.e) - 15'sd1;
      s2_next.fexp = 13'd1;
    end
    s2_next.left = !shv[14];
    ashv         = s2_next.left ? shv : -shv;
    s2_next.amt  = (ashv > 15'sd127) ? 7'd127 : ashv[6:0];
  end

  // barrel shift, right shifts collect sticky
  always_comb begin
    s3_next.nan  = s2.nan;
    s3_next.inf  = s2.inf;
    s3_next.sign = s2.sign;
    s3_next.fexp = s2.fexp;
    if (s2.left) begin
      s3_next.m      = s2.m << s2.amt;
      s3_next.sticky = 1'b0;
    end else begin
      s3_next.m      = s2.m >> s2.amt;
      s3_next.sticky = |(s2.m & ~({108{1'b1}} << s2.amt));
    end
  end

  // round to nearest even and pack
  always_comb begin
    logic [52:0] mant;
    logic [53:0] mr;
    logic [12:0] ex;
    logic        up;
    logic        st;
    st   = (|s3.m[52:0]) | s3.sticky;
    up   = s3.m[53] & (st | s3.m[54]);
    mr   = {1'b0, s3.m[106:54]} + 54'(up);
    if (mr[53]) begin
      mant = mr[53:1];
      ex   = s3.fexp + 13'd1;
    end else begin
      mant = mr[52:0];
      ex   = s3.fexp;
    end
    if (s3.nan) begin
      res_next = QNAN_BITS;
    end else if (s3.inf || (mant[52] && ex >= 13'(EXP_ALL))) begin
      res_next = {s3.sign, EXP_ALL, 52'd0};
    end else begin
      res_next = {s3.sign, mant[52] ? ex[10:0] : 11'd0, mant[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1 <= op;
    if (en[1]) s2 <= s2_next;
    if (en[2]) s3 <= s3_next;
    if (en[3]) result <= res_next;
  end

endmodule

/* hdl/float_tolerance_compare_core.sv */
// ----------------------------------------------------------------------------
// float_tolerance_compare_core
// throughput: one operand pair per cycle, stalls back-pressure stage by stage
// depth is set by the chain multiply -> add, each rounded on its own; the subtract runs alongside
// reset: synchronous rst clears all valid bits and the tolerance registers
// ----------------------------------------------------------------------------
module float_tolerance_compare_core import ftc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value_a,
  input  logic [63:0] value_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_close,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // stage map
  //   0      input registers
  //   1      subtract front end, multiplier operands
  //   2..5   difference normalize/round
  //   2..3   partial products and their sum
  //   4..7   product normalize/round
  //   8      bound adder front end
  //   9..12  bound normalize/round
  //   13     compare result register
  localparam int Last = 13;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sign;
    logic signed [13:0] e;
  } mul_meta_t;

  logic [Last:0] v;
  logic [Last:0] en;

  logic [63:0] rel_tol;
  logic [63:0] abs_tol;
  logic        nan_eq;

  logic [63:0] a0, b0;

  // special-case verdict travels alongside the arithmetic
  logic sp_flag [1:Last-1];
  logic sp_val  [1:Last-1];
  logic sp_flag_next, sp_val_next;

  add_prep_t dprep1, dprep1_next;
  mul_meta_t mul1, mul1_next, mul2, mul3;
  logic [52:0] ma1, mb1, ma1_next, mb1_next;

  logic [53:0]  pp_hh;
  logic [52:0]  pp_hl, pp_lh;
  logic [51:0]  pp_ll;
  logic [53:0]  mid3;
  logic [105:0] cat3;

  norm_in_t diff_ni, mul_ni, bound_ni;
  logic [63:0] diff5, scaled7, bound12;
  logic [63:0] diff_d [6:Last-1];

  add_prep_t bprep8, bprep8_next;
  logic      cmp;

  // a stage moves when it is empty or the one after it moves
  assign en[Last]        = !v[Last] | out_ready;
  assign en[Last-1:0]    = ~v[Last-1:0] | en[Last:1];
  assign in_ready        = en[0];
  assign out_valid       = v[Last];
  assign cfg_ready       = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      rel_tol <= 64'd0;
      abs_tol <= 64'd0;
      nan_eq  <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k <= Last; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_REL_TOL: rel_tol <= cfg_data;
          CFG_ABS_TOL: abs_tol <= cfg_data;
          CFG_NAN_EQ:  nan_eq  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // stage 0 logic: classify, set up the subtract and the multiply
  always_comb begin
    unpacked_t ua, ub, unb, ur, ubm;
    ua  = unpack(a0);
    ub  = unpack(b0);
    unb = unpack({~b0[63], b0[62:0]});
    ur  = unpack(rel_tol);
    ubm = unpack({1'b0, b0[62:0]});
    // nan beats infinity; infinities must match exactly
    sp_flag_next = ua.nan | ub.nan | ua.inf | ub.inf;
    if (ua.nan || ub.nan) begin
      sp_val_next = nan_eq & ua.nan & ub.nan;
    end else begin
      sp_val_next = (a0 == b0);
    end
    dprep1_next    = add_prep(ua, unb);
    mul1_next.nan  = ur.nan | ubm.nan | (ur.inf & ubm.zero) | (ubm.inf & ur.zero);
    mul1_next.inf  = ur.inf | ubm.inf;
    mul1_next.sign = ur.sign;
    mul1_next.e    = $signed({3'b000, ur.exp}) + $signed({3'b000, ubm.exp}) - 14'sd1021;
    ma1_next       = ur.mant;
    mb1_next       = ubm.mant;
  end

  assign diff_ni = add_core(dprep1);

  // product sum: high and low products do not overlap, the cross terms do
  always_comb begin
    mul_ni.nan  = mul3.nan;
    mul_ni.inf  = mul3.inf;
    mul_ni.sign = mul3.sign;
    mul_ni.e    = mul3.e;
    mul_ni.m    = {2'b00, cat3 + {26'd0, mid3, 26'd0}};
  end

  assign bprep8_next = add_prep(unpack(abs_tol), unpack(scaled7));
  assign bound_ni    = add_core(bprep8);

  // |a-b| <= bound, the sign of the difference is dropped
  always_comb begin
    logic [62:0] dmag;
    logic        bnan;
    dmag = diff_d[Last-1][62:0];
    bnan = (bound12[62:52] == EXP_ALL) && (bound12[51:0] != 52'd0);
    if (bnan) begin
      cmp = 1'b0;
    end else if (bound12[63]) begin
      cmp = (dmag == 63'd0) && (bound12[62:0] == 63'd0);
    end else begin
      cmp = (dmag <= bound12[62:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0 <= value_a;
      b0 <= value_b;
    end
    if (en[1]) begin
      dprep1     <= dprep1_next;
      mul1       <= mul1_next;
      ma1        <= ma1_next;
      mb1        <= mb1_next;
      sp_flag[1] <= sp_flag_next;
      sp_val[1]  <= sp_val_next;
    end
    for (int k = 2; k <= Last-1; k++) begin
      if (en[k]) begin
        sp_flag[k] <= sp_flag[k-1];
        sp_val[k]  <= sp_val[k-1];
      end
    end
    // 27x27-class partial products
    if (en[2]) begin
      pp_hh <= ma1[52:26] * mb1[52:26];
      pp_hl <= ma1[52:26] * mb1[25:0];
      pp_lh <= ma1[25:0] * mb1[52:26];
      pp_ll <= ma1[25:0] * mb1[25:0];
      mul2  <= mul1;
    end
    if (en[3]) begin
      mid3 <= {1'b0, pp_hl} + {1'b0, pp_lh};
      cat3 <= {pp_hh, pp_ll};
      mul3 <= mul2;
    end
    if (en[6]) diff_d[6] <= diff5;
    for (int k = 7; k <= Last-1; k++) begin
      if (en[k]) diff_d[k] <= diff_d[k-1];
    end
    if (en[8]) bprep8 <= bprep8_next;
    if (en[Last]) is_close <= sp_flag[Last-1] ? sp_val[Last-1] : cmp;
  end

  ftc_norm_round u_diff_norm (
    .clk    (clk),
    .en     (en[5:2]),
    .op     (diff_ni),
    .result (diff5)
  );

  ftc_norm_round u_mul_norm (
    .clk    (clk),
    .en     (en[7:4]),
    .op     (mul_ni),
    .result (scaled7)
  );

  ftc_norm_round u_bound_norm (
    .clk    (clk),
    .en     (en[12:9]),
    .op     (bound_ni),
    .result (bound12)
  );

endmodule

/* hdl/ftc_checker.sv */
// ----------------------------------------------------------------------------
// ftc_checker
// port-level checks on the compare core, attached by bind
// ----------------------------------------------------------------------------
module ftc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_close
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_close))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty result register lets the whole pipeline move
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // a taken result frees the pipeline for a new transfer
  a_ready_passes: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

endmodule

bind float_tolerance_compare_core ftc_checker u_ftc_checker (.*);
